// ----- sv/ffta_pkg.sv -----
package ffta_pkg;

    // Region sizes and block table depth.
    localparam int HEAP_BYTES   = 4096;
    localparam int SWAP_BYTES   = 1024;
    localparam int HEADER_BYTES = 16;
    localparam int MAX_BLOCKS   = 64;

    // Field and internal widths.
    localparam int ADDR_W = 12;
    localparam int SIZE_W = 12;
    localparam int IDX_W  = $clog2(MAX_BLOCKS);
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int END_W  = 13;
    localparam int SUM_W  = 14;
    localparam int MEM_AW = IDX_W + 1;

    // Operation codes.
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // Region codes.
    localparam logic REGION_HEAP = 1'b0;
    localparam logic REGION_SWAP = 1'b1;

    // Status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;

    // One block record as stored in the record memory.
    typedef struct packed {
        logic [ADDR_W-1:0] data_start;
        logic [SIZE_W-1:0] size;
        logic              taken;
    } t_rec;

    // Datapath action of one microcode step.
    typedef enum logic [3:0] {
        A_NOP,
        A_SETUP_HEAP,
        A_SETUP_SWAP,
        A_SETUP_FREE,
        A_SCAN,
        A_APPEND,
        A_RESP_OK,
        A_RESP_FAIL,
        A_RESP_UNK
    } t_act;

    // Jump condition of one microcode step.
    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_START,
        C_FREE,
        C_FORCE,
        C_SCAN,
        C_FIT
    } t_cond;

    typedef logic [3:0] t_step;

    // Microcode step addresses.
    localparam t_step SP_IDLE        = 4'd0;
    localparam t_step SP_DISP_FREE   = 4'd1;
    localparam t_step SP_DISP_FORCE  = 4'd2;
    localparam t_step SP_HEAP_SETUP  = 4'd3;
    localparam t_step SP_HEAP_SCAN   = 4'd4;
    localparam t_step SP_HEAP_APPEND = 4'd5;
    localparam t_step SP_SWAP_SETUP  = 4'd6;
    localparam t_step SP_SWAP_SCAN   = 4'd7;
    localparam t_step SP_SWAP_APPEND = 4'd8;
    localparam t_step SP_FAIL        = 4'd9;
    localparam t_step SP_FREE_SETUP  = 4'd10;
    localparam t_step SP_FREE_SCAN   = 4'd11;
    localparam t_step SP_UNKNOWN     = 4'd12;
    localparam t_step SP_OK          = 4'd13;

    typedef struct packed {
        t_act  act;
        t_cond cond;
        t_step tgt;
    } t_uword;

    // Control program, one word per step.
    localparam t_uword UCODE [16] = '{
        '{A_NOP,        C_START,  SP_IDLE},        // wait for a request
        '{A_NOP,        C_FREE,   SP_FREE_SETUP},  // free goes its own way
        '{A_NOP,        C_FORCE,  SP_SWAP_SETUP},  // forced swap skips the heap
        '{A_SETUP_HEAP, C_NEXT,   SP_IDLE},
        '{A_SCAN,       C_SCAN,   SP_OK},          // first fit in the heap
        '{A_APPEND,     C_FIT,    SP_OK},          // bump the heap end
        '{A_SETUP_SWAP, C_NEXT,   SP_IDLE},
        '{A_SCAN,       C_SCAN,   SP_OK},          // first fit in swap
        '{A_APPEND,     C_FIT,    SP_OK},          // bump the swap end
        '{A_RESP_FAIL,  C_ALWAYS, SP_IDLE},
        '{A_SETUP_FREE, C_NEXT,   SP_IDLE},
        '{A_SCAN,       C_SCAN,   SP_OK},          // look up the data start
        '{A_RESP_UNK,   C_ALWAYS, SP_IDLE},        // lookup ran out of records
        '{A_RESP_OK,    C_ALWAYS, SP_IDLE},
        '{A_NOP,        C_ALWAYS, SP_IDLE},
        '{A_NOP,        C_ALWAYS, SP_IDLE}
    };

endpackage

// ----- sv/first_fit_two_region_allocator_top.sv -----
// Channel   Direction  Handshake                     Payload
// request   in         start high while busy low     i_func, i_request_size, i_force_swap,
//                                                    i_free_region, i_free_address
// result    out        o_done high for one cycle     o_status, o_granted_region,
//                                                    o_granted_address
//
// A microcoded sequencer walks the block records of one region at a time, one record
// per cycle through the registered read port of the record memory.
// Allocate: tries the heap, then swap (only swap when forced), stopping on the first hit.
// Free: scans only the named region. busy stays high until the result.
// Reset clears the block counts and end offsets; records are read only below the count.
// The result is shown for exactly one cycle and the receiver cannot stall it.
module first_fit_two_region_allocator_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_func,
    input  logic [ffta_pkg::SIZE_W-1:0]  i_request_size,
    input  logic                         i_force_swap,
    input  logic                         i_free_region,
    input  logic [ffta_pkg::ADDR_W-1:0]  i_free_address,
    output logic                         o_done,
    output logic [1:0]                   o_status,
    output logic                         o_granted_region,
    output logic [ffta_pkg::ADDR_W-1:0]  o_granted_address
);
    import ffta_pkg::*;

    // Sequencer state.
    t_step r_pc, n_pc;
    t_uword uw;

    // Latched request.
    logic              r_func;
    logic [SIZE_W-1:0] r_size;
    logic              r_force;
    logic              r_free_region;
    logic [ADDR_W-1:0] r_faddr;

    // Region state.
    logic [CNT_W-1:0] r_cnt [2];
    logic [END_W-1:0] r_end [2];

    // Scan datapath.
    logic              r_reg;
    logic [CNT_W-1:0]  r_idx;
    logic [IDX_W-1:0]  r_pidx;
    logic              r_pend;
    logic [ADDR_W-1:0] r_gaddr;
    t_rec              r_rd;

    // Record memory, both regions, region bit on top of the address.
    t_rec r_mem [2*MAX_BLOCKS];

    logic              accept;
    logic [CNT_W-1:0]  cur_cnt;
    logic [END_W-1:0]  bytes;
    logic [SUM_W-1:0]  start_ofs;
    logic [SUM_W-1:0]  new_end;
    logic              fit;
    logic              match;
    logic              hit;
    logic              issue;
    logic              exhausted;
    logic              wr_en;
    logic [MEM_AW-1:0] wr_addr;
    t_rec              wr_data;
    logic [MEM_AW-1:0] rd_addr;

    assign uw     = UCODE[r_pc];
    assign busy   = (r_pc != SP_IDLE);
    assign accept = start && !busy;

    // Region-dependent values.
    assign cur_cnt = r_cnt[r_reg];
    assign bytes   = (r_reg == REGION_SWAP) ? END_W'(SWAP_BYTES) : END_W'(HEAP_BYTES);

    // Append check: room in the table and the new block inside the region.
    assign start_ofs = SUM_W'(r_end[r_reg]) + SUM_W'(HEADER_BYTES);
    assign new_end   = start_ofs + SUM_W'(r_size);
    assign fit       = (cur_cnt < CNT_W'(MAX_BLOCKS)) && (start_ofs < SUM_W'(bytes))
                       && (new_end <= SUM_W'(bytes));

    // Record match for the record that came out of the memory this cycle.
    assign match = (r_func == FUNC_FREE) ? (r_rd.data_start == r_faddr)
                                         : (!r_rd.taken && (r_rd.size >= r_size));
    assign hit       = r_pend && match;
    assign issue     = (r_idx < cur_cnt);
    assign exhausted = !r_pend && !issue;

    // Memory port addresses and write data.
    assign rd_addr = {r_reg, r_idx[IDX_W-1:0]};

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = {r_reg, r_pidx};
        wr_data = r_rd;
        if (uw.act == A_SCAN && hit) begin
            wr_en         = 1'b1;
            wr_data.taken = (r_func == FUNC_ALLOC);
        end else if (uw.act == A_APPEND && fit) begin
            wr_en              = 1'b1;
            wr_addr            = {r_reg, cur_cnt[IDX_W-1:0]};
            wr_data.data_start = start_ofs[ADDR_W-1:0];
            wr_data.size       = r_size;
            wr_data.taken      = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd <= r_mem[rd_addr];
    end

    // Next step: fall through, jump, or stay on a waiting or scanning step.
    always_comb begin
        case (uw.cond)
            C_NEXT:   n_pc = r_pc + 4'd1;
            C_ALWAYS: n_pc = uw.tgt;
            C_START:  n_pc = accept ? r_pc + 4'd1 : r_pc;
            C_FREE:   n_pc = (r_func == FUNC_FREE) ? uw.tgt : r_pc + 4'd1;
            C_FORCE:  n_pc = r_force ? uw.tgt : r_pc + 4'd1;
            C_SCAN:   n_pc = hit ? uw.tgt : (exhausted ? r_pc + 4'd1 : r_pc);
            C_FIT:    n_pc = fit ? uw.tgt : r_pc + 4'd1;
            default:  n_pc = SP_IDLE;
        endcase
    end

    // Control state, region counts and end offsets.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= SP_IDLE;
            o_done <= 1'b0;
            r_cnt  <= '{default: '0};
            r_end  <= '{default: '0};
        end else begin
            r_pc   <= n_pc;
            o_done <= (uw.act == A_RESP_OK) || (uw.act == A_RESP_FAIL)
                      || (uw.act == A_RESP_UNK);
            if (uw.act == A_APPEND && fit) begin
                r_cnt[r_reg] <= cur_cnt + CNT_W'(1);
                r_end[r_reg] <= new_end[END_W-1:0];
            end
        end
    end

    // Request capture, scan pointers and result payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func        <= i_func;
            r_size        <= i_request_size;
            r_force       <= i_force_swap;
            r_free_region <= i_free_region;
            r_faddr       <= i_free_address;
        end
        case (uw.act)
            A_SETUP_HEAP: begin
                r_reg  <= REGION_HEAP;
                r_idx  <= '0;
                r_pend <= 1'b0;
            end
            A_SETUP_SWAP: begin
                r_reg  <= REGION_SWAP;
                r_idx  <= '0;
                r_pend <= 1'b0;
            end
            A_SETUP_FREE: begin
                r_reg  <= r_free_region;
                r_idx  <= '0;
                r_pend <= 1'b0;
            end
            A_SCAN: begin
                r_pend <= issue;
                r_pidx <= r_idx[IDX_W-1:0];
                if (issue) begin
                    r_idx <= r_idx + CNT_W'(1);
                end
                if (hit) begin
                    r_gaddr <= r_rd.data_start;
                end
            end
            A_APPEND: begin
                if (fit) begin
                    r_gaddr <= start_ofs[ADDR_W-1:0];
                end
            end
            A_RESP_OK: begin
                o_status <= ST_OK;
                if (r_func == FUNC_FREE) begin
                    o_granted_region  <= REGION_HEAP;
                    o_granted_address <= '0;
                end else begin
                    o_granted_region  <= r_reg;
                    o_granted_address <= r_gaddr;
                end
            end
            A_RESP_FAIL: begin
                o_status          <= ST_NOSPACE;
                o_granted_region  <= REGION_HEAP;
                o_granted_address <= '0;
            end
            A_RESP_UNK: begin
                o_status          <= ST_UNKNOWN;
                o_granted_region  <= REGION_HEAP;
                o_granted_address <= '0;
            end
            default: begin
            end
        endcase
    end

endmodule

// ----- sv/ffta_checker.sv -----
module ffta_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         o_done,
    input logic [1:0]                   o_status,
    input logic                         o_granted_region,
    input logic [ffta_pkg::ADDR_W-1:0]  o_granted_address
);
    import ffta_pkg::*;

    // An accepted request keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("request accepted but block not busy");

    // A result is never shown while a request is still in work.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while busy");

    // Every request ends with exactly the result that releases busy.
    a_fell_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("busy dropped without a result");

    // A failed or unknown-address result carries no grant.
    a_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_status != ST_OK) |-> !o_granted_region && (o_granted_address == '0))
        else $error("grant fields set on a failed request");

endmodule

bind first_fit_two_region_allocator_top ffta_checker u_ffta_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .start             (start),
    .busy              (busy),
    .o_done            (o_done),
    .o_status          (o_status),
    .o_granted_region  (o_granted_region),
    .o_granted_address (o_granted_address)
);
